>>> rtl/core/hrkc_pkg.sv
// ----------------------------------------------------------------------------
// hrkc_pkg
// Shared types, codes and keyword constants for the request keyword classifier
// ----------------------------------------------------------------------------
package hrkc_pkg;

    localparam int unsigned URL_DEPTH   = 7;
    localparam int unsigned AGENT_DEPTH = 11;
    localparam int unsigned BODY_DEPTH  = 13;
    localparam int unsigned SCAN_MAX    = 14;
    localparam int unsigned SCAN_BITS   = SCAN_MAX * 8;

    localparam logic [7:0] MIN_BODY_RESET = 8'd16;
    localparam logic [7:0] COUNT_MAX      = 8'hff;

    typedef logic [SCAN_BITS-1:0] scan_t;

    typedef enum logic [1:0] {
        MODE_URL   = 2'd0,
        MODE_AGENT = 2'd1,
        MODE_BODY  = 2'd2,
        MODE_END   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_URL   = 2'd1,
        CAUSE_AGENT = 2'd2,
        CAUSE_BODY  = 2'd3
    } cause_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic       is_post;
    } in_item_t;

    typedef struct packed {
        logic       is_report;
        logic [1:0] cause;
    } out_item_t;

    // per-cell control, shared by every cell of one window
    typedef struct packed {
        logic shift;
        logic clear;
    } win_ctl_t;

    // keywords, last character in the low byte
    localparam scan_t KW_URL0   = scan_t'(64'h2f66616d696c792f);
    localparam scan_t KW_URL1   = scan_t'(40'h2f7374622f);
    localparam scan_t KW_URL2   = scan_t'(48'h2f636d63632f);
    localparam scan_t KW_AGENT0 = scan_t'(96'h536f667444657465_63746f72);
    localparam scan_t KW_AGENT1 = scan_t'(72'h736f667470726f6265);
    localparam scan_t KW_AGENT2 = scan_t'(72'h536f667450726f6265);
    localparam scan_t KW_BODY0  = scan_t'(80'h737462527_56e54696d65);
    localparam scan_t KW_BODY1  = scan_t'(80'h646576696365496e666f);
    localparam scan_t KW_BODY2  = scan_t'(112'h746370436f6e6e656374496e666f);
    localparam scan_t KW_BODY3  = scan_t'(96'h766f6963655265674_96e666f);

    localparam int unsigned LEN_URL0   = 8;
    localparam int unsigned LEN_URL1   = 5;
    localparam int unsigned LEN_URL2   = 6;
    localparam int unsigned LEN_AGENT0 = 12;
    localparam int unsigned LEN_AGENT1 = 9;
    localparam int unsigned LEN_AGENT2 = 9;
    localparam int unsigned LEN_BODY0  = 10;
    localparam int unsigned LEN_BODY1  = 10;
    localparam int unsigned LEN_BODY2  = 14;
    localparam int unsigned LEN_BODY3  = 12;

    // newest byte in the low byte of scan; true when its tail equals kw
    function automatic logic kw_hit(scan_t scan, scan_t kw, int unsigned len);
        logic hit;
        hit = 1'b1;
        for (int unsigned i = 0; i < SCAN_MAX; i++) begin
            if (i < len && scan[i*8 +: 8] != kw[i*8 +: 8]) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

endpackage

>>> rtl/core/hrkc_byte_cell.sv
// ----------------------------------------------------------------------------
// hrkc_byte_cell
// One byte stage of a window chain, takes its neighbor's byte on shift
// ----------------------------------------------------------------------------
module hrkc_byte_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  hrkc_pkg::win_ctl_t ctl,
    input  logic [7:0]        din,
    output logic [7:0]        dout
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (ctl.clear) begin
            byte_next = 8'h00;
        end else if (ctl.shift) begin
            byte_next = din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'h00;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign dout = byte_reg;

endmodule

>>> rtl/core/hrkc_window.sv
// ----------------------------------------------------------------------------
// hrkc_window
// Chain of byte cells holding the most recent bytes of one field
// ----------------------------------------------------------------------------
module hrkc_window #(
    parameter int unsigned DEPTH = hrkc_pkg::URL_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  hrkc_pkg::win_ctl_t ctl,
    input  logic [7:0]         din,
    output logic [DEPTH*8-1:0] taps
);

    // cell 0 holds the newest stored byte
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [7:0] cell_din;
        if (k == 0) begin : g_head
            assign cell_din = din;
        end else begin : g_link
            assign cell_din = taps[(k-1)*8 +: 8];
        end
        hrkc_byte_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .din     (cell_din),
            .dout    (taps[k*8 +: 8])
        );
    end

endmodule

>>> rtl/core/http_report_keyword_classifier.sv
// ----------------------------------------------------------------------------
// http_report_keyword_classifier
// a verdict is registered into m_data, or into the skid slot if one waits
// throughput: one item per cycle while ready is high; each byte shifts
//   its window chain when accepted, and the keyword compares run on that edge
// ready drops only while both output slots hold unread verdicts
// reset: synchronous, active low; clears windows, flags, count, output slots,
//   and loads min_body_bytes with 16
// ----------------------------------------------------------------------------
module http_report_keyword_classifier (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    // input items
    input  logic                s_valid,
    output logic                s_ready,
    input  hrkc_pkg::in_item_t  s_data,
    // result items
    output logic                m_valid,
    input  logic                m_ready,
    output hrkc_pkg::out_item_t m_data
);

    // handshake and decode
    logic s_fire;
    logic is_url;
    logic is_agent;
    logic is_body;
    logic is_end;
    logic byte_zero;

    assign s_fire    = s_valid && s_ready;
    assign is_url    = s_data.mode == hrkc_pkg::MODE_URL;
    assign is_agent  = s_data.mode == hrkc_pkg::MODE_AGENT;
    assign is_body   = s_data.mode == hrkc_pkg::MODE_BODY;
    assign is_end    = s_data.mode == hrkc_pkg::MODE_END;
    assign byte_zero = s_data.data_byte == 8'h00;

    // request state
    logic [7:0] min_body_bytes_reg;
    logic       url_hit_reg,       url_hit_next;
    logic       agent_hit_reg,     agent_hit_next;
    logic       url_stopped_reg,   url_stopped_next;
    logic       agent_stopped_reg, agent_stopped_next;
    logic [3:0] body_flags_reg,    body_flags_next;
    logic [7:0] body_count_reg,    body_count_next;

    // window control: a zero byte stops url and agent scanning, end clears all
    hrkc_pkg::win_ctl_t url_ctl;
    hrkc_pkg::win_ctl_t agent_ctl;
    hrkc_pkg::win_ctl_t body_ctl;

    assign url_ctl.shift   = s_fire && is_url && !url_stopped_reg && !byte_zero;
    assign url_ctl.clear   = s_fire && is_end;
    assign agent_ctl.shift = s_fire && is_agent && !agent_stopped_reg && !byte_zero;
    assign agent_ctl.clear = s_fire && is_end;
    assign body_ctl.shift  = s_fire && is_body;
    assign body_ctl.clear  = s_fire && is_end;

    // window chains
    logic [hrkc_pkg::URL_DEPTH*8-1:0]   url_taps;
    logic [hrkc_pkg::AGENT_DEPTH*8-1:0] agent_taps;
    logic [hrkc_pkg::BODY_DEPTH*8-1:0]  body_taps;

    hrkc_window #(.DEPTH(hrkc_pkg::URL_DEPTH)) u_url_win (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (url_ctl),
        .din     (s_data.data_byte),
        .taps    (url_taps)
    );

    hrkc_window #(.DEPTH(hrkc_pkg::AGENT_DEPTH)) u_agent_win (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (agent_ctl),
        .din     (s_data.data_byte),
        .taps    (agent_taps)
    );

    hrkc_window #(.DEPTH(hrkc_pkg::BODY_DEPTH)) u_body_win (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (body_ctl),
        .din     (s_data.data_byte),
        .taps    (body_taps)
    );

    // scan views: stored bytes plus the incoming byte in the low byte
    hrkc_pkg::scan_t url_scan;
    hrkc_pkg::scan_t agent_scan;
    hrkc_pkg::scan_t body_scan;

    assign url_scan   = hrkc_pkg::scan_t'({url_taps, s_data.data_byte});
    assign agent_scan = hrkc_pkg::scan_t'({agent_taps, s_data.data_byte});
    assign body_scan  = hrkc_pkg::scan_t'({body_taps, s_data.data_byte});

    logic url_match;
    logic agent_match;
    logic [3:0] body_match;

    assign url_match =
        hrkc_pkg::kw_hit(url_scan, hrkc_pkg::KW_URL0, hrkc_pkg::LEN_URL0) ||
        hrkc_pkg::kw_hit(url_scan, hrkc_pkg::KW_URL1, hrkc_pkg::LEN_URL1) ||
        hrkc_pkg::kw_hit(url_scan, hrkc_pkg::KW_URL2, hrkc_pkg::LEN_URL2);

    assign agent_match =
        hrkc_pkg::kw_hit(agent_scan, hrkc_pkg::KW_AGENT0, hrkc_pkg::LEN_AGENT0) ||
        hrkc_pkg::kw_hit(agent_scan, hrkc_pkg::KW_AGENT1, hrkc_pkg::LEN_AGENT1) ||
        hrkc_pkg::kw_hit(agent_scan, hrkc_pkg::KW_AGENT2, hrkc_pkg::LEN_AGENT2);

    // flag bits: run time, device info, connect info, voice reg info
    assign body_match[0] = hrkc_pkg::kw_hit(body_scan, hrkc_pkg::KW_BODY0, hrkc_pkg::LEN_BODY0);
    assign body_match[1] = hrkc_pkg::kw_hit(body_scan, hrkc_pkg::KW_BODY1, hrkc_pkg::LEN_BODY1);
    assign body_match[2] = hrkc_pkg::kw_hit(body_scan, hrkc_pkg::KW_BODY2, hrkc_pkg::LEN_BODY2);
    assign body_match[3] = hrkc_pkg::kw_hit(body_scan, hrkc_pkg::KW_BODY3, hrkc_pkg::LEN_BODY3);

    // verdict from the state left by the bytes before the end item
    logic   body_long;
    logic   body_pair;
    hrkc_pkg::cause_t   cause;
    hrkc_pkg::out_item_t verdict;

    assign body_long = body_count_reg != 8'h00 && body_count_reg >= min_body_bytes_reg;
    assign body_pair = body_flags_reg[1:0] == 2'b11 || body_flags_reg[3:2] == 2'b11;

    always_comb begin
        cause = hrkc_pkg::CAUSE_NONE;
        if (s_data.is_post) begin
            if (url_hit_reg) begin
                cause = hrkc_pkg::CAUSE_URL;
            end else if (agent_hit_reg) begin
                cause = hrkc_pkg::CAUSE_AGENT;
            end else if (body_long && body_pair) begin
                cause = hrkc_pkg::CAUSE_BODY;
            end
        end
    end

    assign verdict.is_report = cause != hrkc_pkg::CAUSE_NONE;
    assign verdict.cause     = cause;

    // next request state
    always_comb begin
        url_hit_next       = url_hit_reg;
        agent_hit_next     = agent_hit_reg;
        url_stopped_next   = url_stopped_reg;
        agent_stopped_next = agent_stopped_reg;
        body_flags_next    = body_flags_reg;
        body_count_next    = body_count_reg;
        if (s_fire) begin
            case (s_data.mode)
                hrkc_pkg::MODE_URL: begin
                    if (!url_stopped_reg) begin
                        if (byte_zero) begin
                            url_stopped_next = 1'b1;
                        end else if (url_match) begin
                            url_hit_next = 1'b1;
                        end
                    end
                end
                hrkc_pkg::MODE_AGENT: begin
                    if (!agent_stopped_reg) begin
                        if (byte_zero) begin
                            agent_stopped_next = 1'b1;
                        end else if (agent_match) begin
                            agent_hit_next = 1'b1;
                        end
                    end
                end
                hrkc_pkg::MODE_BODY: begin
                    body_flags_next = body_flags_reg | body_match;
                    // count saturates
                    if (body_count_reg != hrkc_pkg::COUNT_MAX) begin
                        body_count_next = body_count_reg + 8'd1;
                    end
                end
                default: begin
                    // end of request clears everything but the register
                    url_hit_next       = 1'b0;
                    agent_hit_next     = 1'b0;
                    url_stopped_next   = 1'b0;
                    agent_stopped_next = 1'b0;
                    body_flags_next    = 4'h0;
                    body_count_next    = 8'h00;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            url_hit_reg       <= 1'b0;
            agent_hit_reg     <= 1'b0;
            url_stopped_reg   <= 1'b0;
            agent_stopped_reg <= 1'b0;
            body_flags_reg    <= 4'h0;
            body_count_reg    <= 8'h00;
        end else begin
            url_hit_reg       <= url_hit_next;
            agent_hit_reg     <= agent_hit_next;
            url_stopped_reg   <= url_stopped_next;
            agent_stopped_reg <= agent_stopped_next;
            body_flags_reg    <= body_flags_next;
            body_count_reg    <= body_count_next;
        end
    end

    // configuration register, written directly
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_body_bytes_reg <= hrkc_pkg::MIN_BODY_RESET;
        end else if (cfg_wr_en) begin
            min_body_bytes_reg <= cfg_wr_data;
        end
    end

    // output register plus a skid slot, so bytes keep flowing while a
    // verdict waits on m_ready
    logic                m_valid_reg,    m_valid_next;
    hrkc_pkg::out_item_t m_data_reg,     m_data_next;
    logic                skid_valid_reg, skid_valid_next;
    hrkc_pkg::out_item_t skid_data_reg,  skid_data_next;
    logic                push;
    logic                pop;

    assign push = s_fire && is_end;
    assign pop  = m_valid_reg && m_ready;

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                // ready is low while the skid slot is full, so no push here
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = push;
                m_data_next  = verdict;
            end
        end else if (push) begin
            if (!m_valid_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = verdict;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = verdict;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign s_ready = !skid_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // assertions

    // the skid slot only fills behind a waiting verdict
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid slot full while output slot empty");

    // an end item leaves the request state cleared
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> (!url_hit_reg && !agent_hit_reg && !url_stopped_reg &&
                  !agent_stopped_reg && body_flags_reg == 4'h0 &&
                  body_count_reg == 8'h00))
        else $error("request state not cleared after end item");

    // a verdict appears only after an end item was accepted
    a_valid_from_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(push))
        else $error("verdict appeared without an end item");

    // report flag and cause agree
    a_report_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.is_report ==
                         (m_data_reg.cause != hrkc_pkg::CAUSE_NONE)))
        else $error("is_report disagrees with cause");

endmodule
